// ===== design/mmfs_pkg.sv =====
// shared types, constants and codes of the min-max feature scaler
// no dependencies; every other design file refers to this package by scoped names

package mmfs_pkg;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int COL_W      = 4;
    localparam int SAMPLE_W   = 16;
    localparam int SCALED_W   = 32;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_W      = 5;

    // default number of feature columns held in the statistics memory
    localparam int FEATURES_DEF = 16;

    // features_in_use after reset
    localparam logic [CFG_W-1:0] FEATURES_IN_USE_RST = CFG_W'(16);

    // divider: magnitude of (x - min) scaled by 2^FRAC_BITS
    localparam int DIVD_W    = SAMPLE_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    // signed quotient after floor correction
    localparam int QS_W      = DIVD_W + 2;

    // inverse transform: scaled * range, floored, plus minimum
    localparam int PROD_W    = SCALED_W + SAMPLE_W + 1;
    localparam int FLOOR_W   = PROD_W - FRAC_BITS;
    localparam int INV_W     = FLOOR_W + 1;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FEATURES_IN_USE = REG_IDX_W'(0);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 2'd0,
        OP_FIT       = 2'd1,
        OP_TRANSFORM = 2'd2,
        OP_INVERSE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_UNFITTED     = 3'd1,
        ST_ZERO_RANGE   = 3'd2,
        ST_SATURATED    = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DIV_INIT,
        S_DIV,
        S_DIV_FIX,
        S_MUL,
        S_INV_FIX,
        S_RESULT
    } state_t;

    typedef struct packed {
        op_t                        operation;
        logic [COL_W-1:0]           column;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SCALED_W-1:0] scaled;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    latch_stats;
        logic    clear_all;
        logic    fit_write;
        logic    load_simple;
        status_t simple_status;
        logic    div_init;
        logic    div_step;
        logic    div_fix;
        logic    mul;
        logic    inv_fix;
        logic    out_load;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic out_of_range;
        logic fitted;
        logic zero_range;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/mmfs_regs.sv =====
// register block of the scaler: features_in_use behind an apb-style port
// depends on mmfs_pkg

module mmfs_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mmfs_pkg::PADDR_W-1:0]        paddr,
    input  logic [mmfs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mmfs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [mmfs_pkg::CFG_W-1:0]          features_in_use
);

    logic [mmfs_pkg::CFG_W-1:0]     features_reg;
    logic [mmfs_pkg::CFG_W-1:0]     features_next;
    logic [mmfs_pkg::REG_IDX_W-1:0] word_idx;
    logic                           wr_en;

    assign word_idx = paddr[mmfs_pkg::PADDR_W-1:2];
    assign wr_en    = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        features_next = features_reg;
        if (wr_en && (word_idx == mmfs_pkg::REG_FEATURES_IN_USE)) begin
            features_next = pwdata[mmfs_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            features_reg <= mmfs_pkg::FEATURES_IN_USE_RST;
        end else begin
            features_reg <= features_next;
        end
    end

    always_comb begin
        unique case (word_idx)
            mmfs_pkg::REG_FEATURES_IN_USE: begin
                prdata = mmfs_pkg::APB_DATA_W'(features_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign features_in_use = features_reg;

endmodule

// ===== design/mmfs_ctrl.sv =====
// controller of the scaler: sequences lookup, fit, divide, multiply and result hand-off
// depends on mmfs_pkg

module mmfs_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  mmfs_pkg::dp_status_t    sts,
    output mmfs_pkg::ctrl_cmd_t     cmd
);

    mmfs_pkg::state_t state_reg;
    mmfs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mmfs_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mmfs_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = mmfs_pkg::S_LOOKUP;
                end
            end
            mmfs_pkg::S_LOOKUP: begin
                if (sts.op == mmfs_pkg::OP_CLEAR || sts.out_of_range ||
                    sts.op == mmfs_pkg::OP_FIT || !sts.fitted) begin
                    state_next = mmfs_pkg::S_RESULT;
                end else if (sts.op == mmfs_pkg::OP_TRANSFORM) begin
                    state_next = sts.zero_range ? mmfs_pkg::S_RESULT : mmfs_pkg::S_DIV_INIT;
                end else begin
                    state_next = mmfs_pkg::S_MUL;
                end
            end
            mmfs_pkg::S_DIV_INIT: begin
                state_next = mmfs_pkg::S_DIV;
            end
            mmfs_pkg::S_DIV: begin
                if (sts.div_last) begin
                    state_next = mmfs_pkg::S_DIV_FIX;
                end
            end
            mmfs_pkg::S_DIV_FIX: begin
                state_next = mmfs_pkg::S_RESULT;
            end
            mmfs_pkg::S_MUL: begin
                state_next = mmfs_pkg::S_INV_FIX;
            end
            mmfs_pkg::S_INV_FIX: begin
                state_next = mmfs_pkg::S_RESULT;
            end
            mmfs_pkg::S_RESULT: begin
                if (sts.out_free) begin
                    state_next = mmfs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mmfs_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd               = '0;
        cmd.simple_status = mmfs_pkg::ST_OK;
        s_ready           = 1'b0;
        unique case (state_reg)
            mmfs_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            mmfs_pkg::S_LOOKUP: begin
                cmd.latch_stats = 1'b1;
                if (sts.op == mmfs_pkg::OP_CLEAR) begin
                    cmd.clear_all   = 1'b1;
                    cmd.load_simple = 1'b1;
                end else if (sts.out_of_range) begin
                    cmd.load_simple   = 1'b1;
                    cmd.simple_status = mmfs_pkg::ST_OUT_OF_RANGE;
                end else if (sts.op == mmfs_pkg::OP_FIT) begin
                    cmd.fit_write   = 1'b1;
                    cmd.load_simple = 1'b1;
                end else if (!sts.fitted) begin
                    cmd.load_simple   = 1'b1;
                    cmd.simple_status = mmfs_pkg::ST_UNFITTED;
                end else if (sts.op == mmfs_pkg::OP_TRANSFORM && sts.zero_range) begin
                    cmd.load_simple   = 1'b1;
                    cmd.simple_status = mmfs_pkg::ST_ZERO_RANGE;
                end
            end
            mmfs_pkg::S_DIV_INIT: begin
                cmd.div_init = 1'b1;
            end
            mmfs_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
            end
            mmfs_pkg::S_DIV_FIX: begin
                cmd.div_fix = 1'b1;
            end
            mmfs_pkg::S_MUL: begin
                cmd.mul = 1'b1;
            end
            mmfs_pkg::S_INV_FIX: begin
                cmd.inv_fix = 1'b1;
            end
            mmfs_pkg::S_RESULT: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // a result never overwrites one still waiting at the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded into a full output register");

endmodule

// ===== design/mmfs_datapath.sv =====
// datapath of the scaler: statistics memory, fitted flags, divider, multiplier,
// result and output registers; depends on mmfs_pkg

module mmfs_datapath #(
    parameter int FEATURES = mmfs_pkg::FEATURES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mmfs_pkg::ctrl_cmd_t             cmd,
    output mmfs_pkg::dp_status_t            sts,
    input  mmfs_pkg::in_item_t              s_item,
    input  logic [mmfs_pkg::CFG_W-1:0]      features_in_use,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mmfs_pkg::out_item_t             m_item
);

    localparam int IDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int SW    = mmfs_pkg::SAMPLE_W;
    localparam int DW    = mmfs_pkg::DIVD_W;
    localparam int QW    = mmfs_pkg::QS_W;
    localparam int VW    = mmfs_pkg::VALUE_W;
    localparam int RW    = mmfs_pkg::INV_W;
    localparam int FLW   = mmfs_pkg::FLOOR_W;

    // statistics memory
    logic signed [SW-1:0] min_mem [FEATURES];
    logic signed [SW-1:0] max_mem [FEATURES];
    logic signed [SW-1:0] rd_min_reg;
    logic signed [SW-1:0] rd_max_reg;

    // captured transaction
    mmfs_pkg::op_t                          op_reg;
    logic [mmfs_pkg::COL_W-1:0]             col_reg;
    logic signed [SW-1:0]                   sample_reg;
    logic signed [mmfs_pkg::SCALED_W-1:0]   scaled_reg;

    logic [FEATURES-1:0] fitted_reg;
    logic [FEATURES-1:0] fitted_next;

    // latched statistics
    logic signed [SW-1:0] lo_reg;
    logic [SW-1:0]        range_reg;
    logic signed [SW:0]   diff_reg;

    // divider
    logic [DW-1:0]                      quo_reg;
    logic [DW-1:0]                      quo_next;
    logic [SW-1:0]                      rem_reg;
    logic [SW-1:0]                      rem_next;
    logic [mmfs_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [mmfs_pkg::DIV_CNT_W-1:0]     cnt_next;

    logic signed [mmfs_pkg::PROD_W-1:0] product_reg;

    logic signed [VW-1:0]   res_value_reg;
    logic signed [VW-1:0]   res_value_next;
    mmfs_pkg::status_t      res_status_reg;
    mmfs_pkg::status_t      res_status_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    mmfs_pkg::out_item_t    m_item_reg;

    // lookup-time values
    logic [IDX_W-1:0]     s_idx;
    logic [IDX_W-1:0]     col_idx;
    logic                 fitted;
    logic                 out_of_range;
    logic signed [SW:0]   range_full;
    logic signed [SW:0]   diff_full;
    logic signed [SW-1:0] new_min;
    logic signed [SW-1:0] new_max;

    // divider step and fix-up
    logic [SW:0]          abs_diff_full;
    logic [SW:0]          shifted;
    logic [SW:0]          trial;
    logic [DW:0]          q_mag;
    logic [QW-1:0]        q_ext;
    logic [QW-1:0]        q_signed;
    logic [QW-VW:0]       q_hi;
    logic                 q_ovf;

    // inverse fix-up
    logic [FLW-1:0]       floor_val;
    logic [RW-1:0]        inv_sum;
    logic [RW-SW:0]       inv_hi;
    logic                 inv_ovf;
    logic [SW-1:0]        inv_sat;
    logic [SW-1:0]        inv_sample;

    assign s_idx   = IDX_W'(s_item.column);
    assign col_idx = IDX_W'(col_reg);
    assign fitted  = fitted_reg[col_idx];

    assign out_of_range = ({1'b0, col_reg} >= features_in_use) ||
                          (32'(col_reg) >= 32'(FEATURES));

    assign range_full = {rd_max_reg[SW-1], rd_max_reg} - {rd_min_reg[SW-1], rd_min_reg};
    assign diff_full  = {sample_reg[SW-1], sample_reg} - {rd_min_reg[SW-1], rd_min_reg};

    assign new_min = (!fitted || (sample_reg < rd_min_reg)) ? sample_reg : rd_min_reg;
    assign new_max = (!fitted || (sample_reg > rd_max_reg)) ? sample_reg : rd_max_reg;

    // memory write on fit, registered read on capture
    always_ff @(posedge aclk) begin
        if (cmd.fit_write) begin
            min_mem[col_idx] <= new_min;
            max_mem[col_idx] <= new_max;
        end
        if (cmd.capture) begin
            rd_min_reg <= min_mem[s_idx];
            rd_max_reg <= max_mem[s_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_item.operation;
            col_reg    <= s_item.column;
            sample_reg <= s_item.sample;
            scaled_reg <= s_item.scaled;
        end
        if (cmd.latch_stats) begin
            lo_reg    <= rd_min_reg;
            range_reg <= range_full[SW-1:0];
            diff_reg  <= diff_full;
        end
        if (cmd.mul) begin
            product_reg <= scaled_reg * $signed({1'b0, range_reg});
        end
    end

    always_comb begin
        fitted_next = fitted_reg;
        if (cmd.clear_all) begin
            fitted_next = '0;
        end else if (cmd.fit_write) begin
            fitted_next[col_idx] = 1'b1;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign abs_diff_full = diff_reg[SW] ? (~diff_reg + 1'b1) : diff_reg;
    assign shifted       = {rem_reg, quo_reg[DW-1]};
    assign trial         = shifted - {1'b0, range_reg};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.div_init) begin
            quo_next = {abs_diff_full[SW-1:0], {mmfs_pkg::FRAC_BITS{1'b0}}};
            rem_next = '0;
            cnt_next = mmfs_pkg::DIV_CNT_W'(DW - 1);
        end else if (cmd.div_step) begin
            if (!trial[SW]) begin
                rem_next = trial[SW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = shifted[SW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // floor for negative numerators, then saturate to the value width
    assign q_mag    = {1'b0, quo_reg} + (DW+1)'(diff_reg[SW] && (rem_reg != '0));
    assign q_ext    = {1'b0, q_mag};
    assign q_signed = diff_reg[SW] ? (~q_ext + 1'b1) : q_ext;
    assign q_hi     = q_signed[QW-1:VW-1];
    assign q_ovf    = !((q_hi == '0) || (q_hi == '1));

    // floor(product / 2^frac) is the arithmetic shift, then add the minimum
    assign floor_val  = product_reg[mmfs_pkg::PROD_W-1:mmfs_pkg::FRAC_BITS];
    assign inv_sum    = {floor_val[FLW-1], floor_val} +
                        {{(RW-SW){lo_reg[SW-1]}}, lo_reg};
    assign inv_hi     = inv_sum[RW-1:SW-1];
    assign inv_ovf    = !((inv_hi == '0) || (inv_hi == '1));
    assign inv_sat    = {inv_sum[RW-1], {(SW-1){~inv_sum[RW-1]}}};
    assign inv_sample = inv_ovf ? inv_sat : inv_sum[SW-1:0];

    always_comb begin
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        if (cmd.load_simple) begin
            res_value_next  = '0;
            res_status_next = cmd.simple_status;
        end else if (cmd.div_fix) begin
            if (q_ovf) begin
                res_value_next  = q_signed[QW-1] ? {1'b1, {(VW-1){1'b0}}}
                                                 : {1'b0, {(VW-1){1'b1}}};
                res_status_next = mmfs_pkg::ST_SATURATED;
            end else begin
                res_value_next  = q_signed[VW-1:0];
                res_status_next = mmfs_pkg::ST_OK;
            end
        end else if (cmd.inv_fix) begin
            res_value_next  = {{(VW-SW){inv_sample[SW-1]}}, inv_sample};
            res_status_next = inv_ovf ? mmfs_pkg::ST_SATURATED : mmfs_pkg::ST_OK;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (cmd.out_load) begin
            m_item_reg.value  <= res_value_reg;
            m_item_reg.status <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fitted_reg  <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fitted_reg  <= fitted_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign sts.op           = op_reg;
    assign sts.out_of_range = out_of_range;
    assign sts.fitted       = fitted;
    assign sts.zero_range   = (rd_max_reg == rd_min_reg);
    assign sts.div_last     = (cnt_reg == '0);
    assign sts.out_free     = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fit_write |=> fitted_reg[$past(col_idx)])
        else $error("fit did not mark its column fitted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_all |=> (fitted_reg == '0))
        else $error("clear left a column fitted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (rem_reg < range_reg))
        else $error("divider remainder not below divisor");

endmodule

// ===== design/min_max_feature_scaler.sv =====
// top level of the per-feature min-max scaler: register block, controller, datapath
// depends on mmfs_pkg, mmfs_regs, mmfs_ctrl, mmfs_datapath
//
//   channel   ports                               direction  moves
//   s_        s_valid s_ready s_item              in         one element per transaction
//   m_        m_valid m_ready m_item              out        one result per transaction
//   apb       psel penable pwrite paddr pwdata    in/out     features_in_use at word 0
//             prdata pready
//
// one item is worked on at a time; the next item is accepted only once the current
// result has gone into the output register: transform runs the 32-step restoring
// divider, one quotient bit a cycle; inverse transform runs one multiply stage and
// one add/saturate stage; clear, fit and every early-status case go straight to the result
// the result sits in an output register, so a stalled m_ready holds only the
// next result; the input side is taken again once that result has moved out
// synchronous active-low reset clears the fitted flags, the controller and
// output valid; min/max memory contents stay undefined until a fit writes them

module min_max_feature_scaler #(
    parameter int FEATURES = mmfs_pkg::FEATURES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mmfs_pkg::in_item_t                  s_item,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output mmfs_pkg::out_item_t                 m_item,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mmfs_pkg::PADDR_W-1:0]        paddr,
    input  logic [mmfs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mmfs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // number of columns in use, from the register block
    logic [mmfs_pkg::CFG_W-1:0] features_in_use;

    // controller and datapath talk only through these
    mmfs_pkg::ctrl_cmd_t  cmd;
    mmfs_pkg::dp_status_t sts;

    mmfs_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .features_in_use (features_in_use)
    );

    // sequencer: lookup, then fit write, divide or multiply, then result hand-off
    mmfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // statistics memory, arithmetic and the output register
    mmfs_datapath #(
        .FEATURES (FEATURES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_item          (s_item),
        .features_in_use (features_in_use),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for min_max_feature_scaler: directed corners, then random phases
// depends on mmfs_pkg and the min_max_feature_scaler design files

module tb;

    // slowest pass: ~1600 transactions, each through the block with the longest drawn send gap
    // and receive stall, plus one long hold and the register writes
    localparam int CYCLE_LIMIT      = 500000;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_ELEMENTS   = 258;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LOG_CAP          = 200;

    localparam longint VALUE_MAX  = 64'sd2147483647;
    localparam longint VALUE_MIN  = -64'sd2147483648;
    localparam longint SAMPLE_MAX = 64'sd32767;
    localparam longint SAMPLE_MIN = -64'sd32768;

    localparam logic [mmfs_pkg::PADDR_W-1:0] FEATURES_ADDR =
        {mmfs_pkg::REG_FEATURES_IN_USE, 2'b00};

    // clock, reset and block ports
    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    mmfs_pkg::in_item_t              s_item  = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    mmfs_pkg::out_item_t             m_item;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [mmfs_pkg::PADDR_W-1:0]    paddr   = '0;
    logic [mmfs_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [mmfs_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // scaler statistics as the testbench sees them
    logic [mmfs_pkg::CFG_W-1:0] cfg_features = mmfs_pkg::FEATURES_IN_USE_RST;
    logic signed [15:0]   col_min [16];
    logic signed [15:0]   col_max [16];
    logic [15:0]          col_fitted = '0;

    // stimulus and scoreboard state
    mmfs_pkg::in_item_t   elements_to_send [$];
    mmfs_pkg::out_item_t  predicted_outputs [$];
    logic [15:0]          base_of_col [16];
    logic                 burst_mode     = 1'b0;
    logic                 long_hold_done = 1'b0;
    int                   send_gap       = 0;
    int                   recv_hold      = 0;
    int                   results_taken  = 0;
    int                   mismatches     = 0;
    int                   cycle_count    = 0;
    mmfs_pkg::out_item_t  want;

    always #2 aclk = ~aclk;

    min_max_feature_scaler uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // one line per mismatch, the log is capped so a broken run stays readable
    task automatic flag_mismatch(input string msg);
        if (mismatches < LOG_CAP) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // expected result of one element; updates the fitted statistics like the block does
    function automatic mmfs_pkg::out_item_t scale_element(input mmfs_pkg::in_item_t e);
        mmfs_pkg::out_item_t r;
        int        c;
        longint    x, lo, span, num, quo, prod, res;
        c      = int'(e.column);
        x      = longint'($signed(e.sample));
        r      = '0;
        r.status = mmfs_pkg::ST_OK;
        if (e.operation == mmfs_pkg::OP_CLEAR) begin
            // clear ignores the column field, even an unused one
            col_fitted = '0;
        end else if ({1'b0, e.column} >= cfg_features) begin
            r.status = mmfs_pkg::ST_OUT_OF_RANGE;
        end else if (e.operation == mmfs_pkg::OP_FIT) begin
            if (!col_fitted[c]) begin
                col_min[c]    = e.sample;
                col_max[c]    = e.sample;
                col_fitted[c] = 1'b1;
            end else begin
                if (x < longint'(col_min[c])) col_min[c] = e.sample;
                if (x > longint'(col_max[c])) col_max[c] = e.sample;
            end
        end else if (!col_fitted[c]) begin
            r.status = mmfs_pkg::ST_UNFITTED;
        end else begin
            lo   = longint'(col_min[c]);
            span = longint'(col_max[c]) - lo;
            if (e.operation == mmfs_pkg::OP_TRANSFORM) begin
                if (span == 0) begin
                    r.status = mmfs_pkg::ST_ZERO_RANGE;
                end else begin
                    // floor of (x - min) * 2^16 / range
                    num = (x - lo) * 64'sd65536;
                    quo = num / span;
                    if (num % span != 0 && num < 0) quo = quo - 1;
                    if (quo > VALUE_MAX) begin
                        r.value  = 32'(VALUE_MAX);
                        r.status = mmfs_pkg::ST_SATURATED;
                    end else if (quo < VALUE_MIN) begin
                        r.value  = 32'(VALUE_MIN);
                        r.status = mmfs_pkg::ST_SATURATED;
                    end else begin
                        r.value = 32'(quo);
                    end
                end
            end else begin
                // floor of scaled * range / 2^16, then add the minimum
                prod = longint'($signed(e.scaled)) * span;
                res  = (prod >>> mmfs_pkg::FRAC_BITS) + lo;
                if (res > SAMPLE_MAX) begin
                    r.value  = 32'(SAMPLE_MAX);
                    r.status = mmfs_pkg::ST_SATURATED;
                end else if (res < SAMPLE_MIN) begin
                    r.value  = 32'(SAMPLE_MIN);
                    r.status = mmfs_pkg::ST_SATURATED;
                end else begin
                    r.value = 32'(res);
                end
            end
        end
        return r;
    endfunction

    task automatic add_element(input mmfs_pkg::op_t op, input logic [3:0] col,
                               input logic [15:0] x, input logic [31:0] s);
        mmfs_pkg::in_item_t e;
        e.operation = op;
        e.column    = col;
        e.sample    = x;
        e.scaled    = s;
        elements_to_send.push_back(e);
    endtask

    // random element: mostly in-use columns and fits followed by lookups,
    // samples clustered around a per-column base so narrow ranges show up
    function automatic mmfs_pkg::in_item_t make_element();
        mmfs_pkg::in_item_t e;
        int       pick, c;
        pick = $urandom_range(0, 99);
        if (pick < 3)       e.operation = mmfs_pkg::OP_CLEAR;
        else if (pick < 35) e.operation = mmfs_pkg::OP_FIT;
        else if (pick < 72) e.operation = mmfs_pkg::OP_TRANSFORM;
        else                e.operation = mmfs_pkg::OP_INVERSE;
        if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 15);
        else                           c = $urandom_range(0, int'(cfg_features) - 1);
        e.column = 4'(c);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       e.sample = 16'h8000;
                    1:       e.sample = 16'h7FFF;
                    2:       e.sample = 16'h0000;
                    default: e.sample = 16'hFFFF;
                endcase
            end
            1, 2, 3, 4: e.sample = 16'($urandom);
            default:    e.sample = base_of_col[c] + 16'($urandom_range(0, 16)) - 16'd8;
        endcase
        case ($urandom_range(0, 3))
            0:       e.scaled = $urandom;
            3:       e.scaled = $urandom_range(0, 262144) - 32'd131072;
            default: e.scaled = $urandom_range(0, 65536);
        endcase
        return e;
    endfunction

    // idle means nothing queued, nothing offered and nothing outstanding;
    // checked at the falling edge so every rising-edge update has landed
    task automatic wait_idle();
        do @(negedge aclk);
        while (elements_to_send.size() != 0 || s_valid || predicted_outputs.size() != 0);
    endtask

    // write features_in_use, then read it back
    task automatic program_features(input logic [mmfs_pkg::CFG_W-1:0] n_cols);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FEATURES_ADDR;
        pwdata  <= mmfs_pkg::APB_DATA_W'(n_cols);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        cfg_features = n_cols;
        // read transfer follows with psel kept high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        if (prdata !== mmfs_pkg::APB_DATA_W'(n_cols)) begin
            flag_mismatch($sformatf("features_in_use read %0d, wrote %0d", prdata, n_cols));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // driver: holds the payload until the transaction completes, then waits
    // the gap drawn for that element before offering the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predicted_outputs.push_back(scale_element(s_item));
            end
            if (send_gap != 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (elements_to_send.size() != 0) begin
                s_item   <= elements_to_send.pop_front();
                s_valid  <= 1'b1;
                send_gap <= burst_mode ? 0 : $urandom_range(0, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction,
    // then, outside burst mode, drops ready for a drawn number of cycles; once it holds off long
    // enough for the block to back up into the input channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_hold <= 0;
        end else if (m_valid && m_ready) begin
            if (predicted_outputs.size() == 0) begin
                flag_mismatch($sformatf("unexpected result value %0d status %0d",
                                        m_item.value, m_item.status));
            end else begin
                want = predicted_outputs.pop_front();
                if (m_item.value !== want.value) begin
                    flag_mismatch($sformatf("result %0d value %0d, predicted %0d",
                                            results_taken, m_item.value, want.value));
                end
                if (m_item.status !== want.status) begin
                    flag_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                            results_taken, m_item.status, want.status));
                end
            end
            results_taken++;
            if (!long_hold_done && results_taken == LONG_HOLD_AT) begin
                long_hold_done <= 1'b1;
                recv_hold      <= LONG_HOLD_CYCLES;
                m_ready        <= 1'b0;
            end else if (burst_mode) begin
                recv_hold <= 0;
                m_ready   <= 1'b1;
            end else begin
                recv_hold <= $urandom_range(0, 8);
                m_ready   <= 1'b0;
            end
        end else if (recv_hold != 0) begin
            recv_hold <= recv_hold - 1;
            m_ready   <= (recv_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("min_max_feature_scaler verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int ph, k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: unfitted columns right after reset
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd0, 16'd0, 32'd0);
        add_element(mmfs_pkg::OP_INVERSE,   4'd0, 16'd0, 32'd0);
        // full sample span on column 0: both ends of the scale, inverse saturation
        add_element(mmfs_pkg::OP_FIT,       4'd0, 16'h8000, 32'd0);
        add_element(mmfs_pkg::OP_FIT,       4'd0, 16'h7FFF, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd0, 16'h7FFF, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd0, 16'h8000, 32'd0);
        add_element(mmfs_pkg::OP_INVERSE,   4'd0, 16'd0, 32'h7FFF_FFFF);
        add_element(mmfs_pkg::OP_INVERSE,   4'd0, 16'd0, 32'h8000_0000);
        add_element(mmfs_pkg::OP_INVERSE,   4'd0, 16'd0, 32'h0001_0000);
        // single fit on the top column: zero range in transform, minimum back from inverse
        add_element(mmfs_pkg::OP_FIT,       4'd15, 16'd5, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd15, 16'd5, 32'd0);
        add_element(mmfs_pkg::OP_INVERSE,   4'd15, 16'd0, 32'd12345);
        // range of one: transform saturates high and low
        add_element(mmfs_pkg::OP_FIT,       4'd2, 16'h8000, 32'd0);
        add_element(mmfs_pkg::OP_FIT,       4'd2, 16'h8001, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd2, 16'h7FFF, 32'd0);
        add_element(mmfs_pkg::OP_FIT,       4'd3, 16'h7FFE, 32'd0);
        add_element(mmfs_pkg::OP_FIT,       4'd3, 16'h7FFF, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd3, 16'h8000, 32'd0);
        // negative inexact quotient and product round toward minus infinity
        add_element(mmfs_pkg::OP_FIT,       4'd4, 16'd0, 32'd0);
        add_element(mmfs_pkg::OP_FIT,       4'd4, 16'd3, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd4, 16'hFFFF, 32'd0);
        add_element(mmfs_pkg::OP_INVERSE,   4'd4, 16'd0, 32'hFFFF_FFFF);
        // clear forgets every column
        add_element(mmfs_pkg::OP_CLEAR,     4'd9, 16'd0, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd0, 16'd0, 32'd0);
        wait_idle();

        // one column in use: the rest are out of range, clear still works
        program_features(mmfs_pkg::CFG_W'(1));
        add_element(mmfs_pkg::OP_FIT,       4'd1, 16'd7, 32'd0);
        add_element(mmfs_pkg::OP_TRANSFORM, 4'd15, 16'd7, 32'd0);
        add_element(mmfs_pkg::OP_INVERSE,   4'd1, 16'd0, 32'd100);
        add_element(mmfs_pkg::OP_CLEAR,     4'd15, 16'd0, 32'd0);
        wait_idle();

        // random phases, each under its own column count
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0, 3:    program_features(mmfs_pkg::CFG_W'(16));
                1:       program_features(mmfs_pkg::CFG_W'(1));
                default: program_features(mmfs_pkg::CFG_W'($urandom_range(2, 15)));
            endcase
            burst_mode = (ph == 1 || ph == 4);
            for (k = 0; k < 16; k++) base_of_col[k] = 16'($urandom);
            for (k = 0; k < PHASE_ELEMENTS; k++) elements_to_send.push_back(make_element());
            wait_idle();
        end

        // let a stray late result show up before deciding
        repeat (64) @(posedge aclk);
        if (predicted_outputs.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", predicted_outputs.size()));
        end
        if (mismatches == 0) begin
            $display("min_max_feature_scaler verification clean");
        end else begin
            $display("min_max_feature_scaler verification failed");
        end
        $finish;
    end

endmodule
